### rtl/srp_pkg.sv
// Shared types, constants and the fit check of the shelf rectangle packer.
// Used by shelf_rectangle_packer_core; depends on nothing.
package srp_pkg;

  // Shelf table geometry
  localparam int MaxShelves = 64;
  localparam int IdxW       = $clog2(MaxShelves);
  localparam int CntW       = $clog2(MaxShelves + 1);

  // Stored field widths
  localparam int TopW  = 17;
  localparam int CurW  = 18;
  localparam int TallW = 17;
  localparam int SizeW = 17;
  localparam int LimW  = 18;

  // Register reset values and the page number limit
  localparam logic [15:0] SheetWidthRst  = 16'd3360;
  localparam logic [15:0] SheetHeightRst = 16'd4752;
  localparam logic [11:0] PaddingRst     = 12'd80;
  localparam logic [15:0] PageMax        = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHEET_WIDTH  = 2'd0,
    CFG_SHEET_HEIGHT = 2'd1,
    CFG_PADDING      = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } rect_t;

  typedef struct packed {
    logic [15:0] page_no;
    logic [15:0] x_offset;
    logic [15:0] y_offset;
    logic        new_page;
  } place_t;

  typedef struct packed {
    logic [TopW-1:0]  top;
    logic [CurW-1:0]  cursor;
    logic [TallW-1:0] tallest;
  } shelf_t;

  localparam int ShelfW = $bits(shelf_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  // Signed fit check: base + size <= lim
  function automatic logic fits(logic [CurW-1:0] base, logic [SizeW-1:0] size,
                                logic signed [LimW-1:0] lim);
    logic signed [LimW+1:0] sum;
    logic signed [LimW+1:0] lim_x;
    sum   = signed'({2'b00, base}) + signed'({3'b000, size});
    lim_x = {{2{lim[LimW-1]}}, lim};
    return sum <= lim_x;
  endfunction

endpackage

### rtl/srp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/shelf_rectangle_packer_core.sv
// Shelf first-fit rectangle packer: top level, sequencer and datapath.
// Depends on srp_pkg and srp_ram.
//
// Scan: the stored shelves (1..64) are read in order, one shelf per cycle from
// the table RAM, and the result strobe rises once the rectangle fits one of
// them; a miss on all stored shelves adds the new-shelf decision state.
// busy drops with the strobe.
// Reset: page 1, one shelf at (padding 80, padding 80), registers at defaults.
// Results cannot be stalled; each result is shown for one cycle only.
module shelf_rectangle_packer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  srp_pkg::rect_t  rect_i,
  output logic            res_valid_o,
  output srp_pkg::place_t res_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);

  localparam int IdxW = srp_pkg::IdxW;
  localparam int CntW = srp_pkg::CntW;

  // Configuration registers
  logic [15:0] sheet_width_q, sheet_height_q;
  logic [11:0] padding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sheet_width_q  <= srp_pkg::SheetWidthRst;
      sheet_height_q <= srp_pkg::SheetHeightRst;
      padding_q      <= srp_pkg::PaddingRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srp_pkg::CFG_SHEET_WIDTH:  sheet_width_q  <= cfg_data_i;
        srp_pkg::CFG_SHEET_HEIGHT: sheet_height_q <= cfg_data_i;
        srp_pkg::CFG_PADDING:      padding_q      <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  srp_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] scan_idx_q, scan_idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     page_q, page_d;
  logic            e0_rst_q, e0_rst_d;
  logic [srp_pkg::SizeW-1:0] pw_q, pw_d, ph_q, ph_d;
  logic signed [srp_pkg::LimW-1:0] xlim_q, xlim_d, ylim_q, ylim_d;
  logic [srp_pkg::CurW-1:0] ny_q, ny_d;
  logic            res_valid_d;
  srp_pkg::place_t res_d;

  // RAM ports
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr, ram_raddr;
  srp_pkg::shelf_t        ram_wdata, ram_rdata;
  logic [srp_pkg::ShelfW-1:0] ram_rbits;

  srp_ram #(
    .Width (srp_pkg::ShelfW),
    .Depth (srp_pkg::MaxShelves)
  ) u_shelf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  // Entry 0 reads as its reset contents until first written
  srp_pkg::shelf_t shelf_cur;
  always_comb begin
    ram_rdata = srp_pkg::shelf_t'(ram_rbits);
    shelf_cur = ram_rdata;
    if (e0_rst_q && scan_idx_q == '0) begin
      shelf_cur.top     = srp_pkg::TopW'(srp_pkg::PaddingRst);
      shelf_cur.cursor  = srp_pkg::CurW'(srp_pkg::PaddingRst);
      shelf_cur.tallest = '0;
    end
  end

  // Shared fit unit: x and y checks on the shelf being scanned, y check for a new shelf
  logic fit_x, fit_y, fit_new, last_shelf, table_full;
  always_comb begin
    fit_x      = srp_pkg::fits(shelf_cur.cursor, pw_q, xlim_q);
    fit_y      = srp_pkg::fits({1'b0, shelf_cur.top}, ph_q, ylim_q);
    fit_new    = srp_pkg::fits(ny_q, ph_q, ylim_q);
    last_shelf = scan_idx_q == IdxW'(count_q - CntW'(1));
    table_full = count_q == CntW'(srp_pkg::MaxShelves);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srp_pkg::ST_IDLE: begin
        if (start) state_d = srp_pkg::ST_SCAN;
      end
      srp_pkg::ST_SCAN: begin
        if (fit_x && fit_y)  state_d = srp_pkg::ST_IDLE;
        else if (last_shelf) state_d = srp_pkg::ST_DECIDE;
      end
      srp_pkg::ST_DECIDE: state_d = srp_pkg::ST_IDLE;
      default:            state_d = srp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    scan_idx_d  = scan_idx_q;
    count_d     = count_q;
    page_d      = page_q;
    e0_rst_d    = e0_rst_q;
    pw_d        = pw_q;
    ph_d        = ph_q;
    xlim_d      = xlim_q;
    ylim_d      = ylim_q;
    ny_d        = ny_q;
    res_valid_d = 1'b0;
    res_d       = res_o;
    ram_we      = 1'b0;
    ram_waddr   = scan_idx_q;
    ram_wdata   = shelf_cur;
    ram_raddr   = scan_idx_q + IdxW'(1);
    case (state_q)
      srp_pkg::ST_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          scan_idx_d = '0;
          pw_d   = {1'b0, rect_i.rect_width} + srp_pkg::SizeW'(padding_q);
          ph_d   = {1'b0, rect_i.rect_height} + srp_pkg::SizeW'(padding_q);
          xlim_d = signed'({2'b00, sheet_width_q}) - signed'({6'b0, padding_q});
          ylim_d = signed'({2'b00, sheet_height_q}) - signed'({6'b0, padding_q});
        end
      end
      srp_pkg::ST_SCAN: begin
        scan_idx_d = scan_idx_q + IdxW'(1);
        ny_d = {1'b0, shelf_cur.top} + {1'b0, shelf_cur.tallest};
        if (fit_x && fit_y) begin
          // Place on this shelf
          ram_we           = 1'b1;
          ram_wdata.cursor = shelf_cur.cursor + {1'b0, pw_q};
          if (shelf_cur.tallest < ph_q) ram_wdata.tallest = ph_q;
          if (scan_idx_q == '0) e0_rst_d = 1'b0;
          res_valid_d       = 1'b1;
          res_d.page_no     = page_q;
          res_d.x_offset    = shelf_cur.cursor[15:0];
          res_d.y_offset    = shelf_cur.top[15:0];
          res_d.new_page    = 1'b0;
        end
      end
      srp_pkg::ST_DECIDE: begin
        res_valid_d = 1'b1;
        ram_we      = 1'b1;
        if (!table_full && fit_new) begin
          // Open a new shelf under the last one
          ram_waddr         = count_q[IdxW-1:0];
          ram_wdata.top     = ny_q[srp_pkg::TopW-1:0];
          ram_wdata.cursor  = srp_pkg::CurW'(padding_q) + {1'b0, pw_q};
          ram_wdata.tallest = ph_q;
          count_d           = count_q + CntW'(1);
          res_d.page_no     = page_q;
          res_d.x_offset    = 16'(padding_q);
          res_d.y_offset    = ny_q[15:0];
          res_d.new_page    = 1'b0;
        end else begin
          // Start a new page, placed without a check
          if (page_q != srp_pkg::PageMax) page_d = page_q + 16'd1;
          ram_waddr         = '0;
          ram_wdata.top     = srp_pkg::TopW'(padding_q);
          ram_wdata.cursor  = srp_pkg::CurW'(padding_q) + {1'b0, pw_q};
          ram_wdata.tallest = ph_q;
          count_d           = CntW'(1);
          e0_rst_d          = 1'b0;
          res_d.page_no     = page_d;
          res_d.x_offset    = 16'(padding_q);
          res_d.y_offset    = 16'(padding_q);
          res_d.new_page    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srp_pkg::ST_IDLE;
      scan_idx_q  <= '0;
      count_q     <= CntW'(1);
      page_q      <= 16'd1;
      e0_rst_q    <= 1'b1;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      count_q     <= count_d;
      page_q      <= page_d;
      e0_rst_q    <= e0_rst_d;
      res_valid_o <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pw_q   <= pw_d;
    ph_q   <= ph_d;
    xlim_q <= xlim_d;
    ylim_q <= ylim_d;
    ny_q   <= ny_d;
    res_o  <= res_d;
  end

  assign busy = state_q != srp_pkg::ST_IDLE;

  // Checks
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy) else $error("result beat while busy");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item left block idle");
  a_count_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CntW'(srp_pkg::MaxShelves))
    else $error("shelf count out of range");
  a_page_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.page_no == page_q) else $error("page mismatch");
  a_fresh_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.new_page) |-> count_q == CntW'(1))
    else $error("new page without shelf reset");

endmodule
